### rtl/csd_pkg.sv
// Shared constants, register indexes and helpers for the CAN signal decoder.
package csd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int DATA_BITS     = 64;
    localparam int LEN_BITS      = 7;
    localparam int POS_BITS      = 6;
    localparam int FACTOR_BITS   = 32;
    localparam int OFFSET_BITS   = 48;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_BIT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIT_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIG_ENDIAN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IS_SIGNED    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_OFFSET = 3'd5;

    localparam logic [LEN_BITS-1:0] MAX_LEN = 7'd64;

    localparam logic [DATA_BITS-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_BITS-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

    // Low-order mask of len ones, len from 0 to 64.
    function automatic logic [DATA_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
        logic [DATA_BITS-1:0] m;
        begin
            if (len >= MAX_LEN)
            begin
                m = '1;
            end
            else
            begin
                m = ~({DATA_BITS{1'b1}} << len[POS_BITS-1:0]);
            end
            return m;
        end
    endfunction

endpackage

### rtl/can_signal_decode.sv
// CAN signal decoder: five-stage pipeline from frame payload to scaled signal value.
//
// Takes one frame per clock on s_axis while s_axis_tready is high and returns one
// result per frame on m_axis. The five stages are: byte masking and alignment
// shift, field cut and sign extension, two 33x32 partial products, product sum,
// offset add with saturation to 64 bits. A stall on m_axis backs up through the
// stages one at a time, so empty stages still take frames. Configuration writes
// on the cfg port are taken in any cycle (cfg_ready is always high) but must only
// be issued while no frame is in flight.
module can_signal_decode
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] payload_bits, [67:64] payload_len, [71:68] zero
    input  logic [71:0]  s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] raw_field, [127:64] scaled_value
    output logic [127:0] m_axis_tdata,
    // [0] saturated
    output logic         m_axis_tuser
);

    // configuration registers
    logic [csd_pkg::POS_BITS-1:0]    start_bit_reg;
    logic [csd_pkg::LEN_BITS-1:0]    bit_length_reg;
    logic                            big_endian_reg;
    logic                            is_signed_reg;
    logic [csd_pkg::FACTOR_BITS-1:0] scale_factor_reg;
    logic [csd_pkg::OFFSET_BITS-1:0] scale_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bit_reg    <= '0;
            bit_length_reg   <= 7'd8;
            big_endian_reg   <= 1'b0;
            is_signed_reg    <= 1'b0;
            scale_factor_reg <= 32'sd65536;
            scale_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csd_pkg::REG_START_BIT:    start_bit_reg    <= cfg_data[csd_pkg::POS_BITS-1:0];
                csd_pkg::REG_BIT_LENGTH:   bit_length_reg   <= cfg_data[csd_pkg::LEN_BITS-1:0];
                csd_pkg::REG_BIG_ENDIAN:   big_endian_reg   <= cfg_data[0];
                csd_pkg::REG_IS_SIGNED:    is_signed_reg    <= cfg_data[0];
                csd_pkg::REG_SCALE_FACTOR:
                    scale_factor_reg <= cfg_data[csd_pkg::FACTOR_BITS-1:0];
                csd_pkg::REG_SCALE_OFFSET:
                    scale_offset_reg <= cfg_data[csd_pkg::OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped signal length
    logic [csd_pkg::LEN_BITS-1:0] len_clamped;
    assign len_clamped = (bit_length_reg > csd_pkg::MAX_LEN) ? csd_pkg::MAX_LEN : bit_length_reg;

    // pipeline flow control: a stage loads when empty or when it hands on
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !s5_valid_reg || m_axis_tready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ---------------- stage 1: mask bytes, align ----------------
    logic [63:0] payload_bits;
    logic [3:0]  payload_len;
    logic [3:0]  nbytes;
    logic [63:0] masked;
    logic [63:0] reversed;
    logic [5:0]  stream_start;
    logic [6:0]  nbits;
    logic [6:0]  avail;
    logic [6:0]  moto_len;
    logic        zero_case;

    logic [63:0] s1_word_next;
    logic [6:0]  s1_flen_next;
    logic [63:0] s1_word_reg;
    logic [6:0]  s1_flen_reg;
    logic        s1_zero_reg;

    assign payload_bits = s_axis_tdata[63:0];
    assign payload_len  = s_axis_tdata[67:64];

    always_comb
    begin
        nbytes = (payload_len > 4'(csd_pkg::PAYLOAD_BYTES)) ?
                 4'(csd_pkg::PAYLOAD_BYTES) : payload_len;
        masked   = '0;
        reversed = '0;
        for (int k = 0; k < csd_pkg::PAYLOAD_BYTES; k++)
        begin
            if (4'(k) < nbytes)
            begin
                masked[8*k +: 8] = payload_bits[8*k +: 8];
            end
        end
        // byte-reverse so Motorola bits run from the top of the word downward
        for (int k = 0; k < 8; k++)
        begin
            reversed[8*(7-k) +: 8] = masked[8*k +: 8];
        end
        stream_start = {start_bit_reg[5:3], ~start_bit_reg[2:0]};
        nbits        = {nbytes, 3'b000};
        avail        = nbits - {1'b0, stream_start};
        if (nbits > {1'b0, stream_start})
        begin
            moto_len = (len_clamped < avail) ? len_clamped : avail;
        end
        else
        begin
            moto_len = '0;
        end
        zero_case = (nbytes == 4'd0) || (len_clamped == 7'd0);
        if (big_endian_reg)
        begin
            s1_word_next = reversed << stream_start;
            s1_flen_next = moto_len;
        end
        else
        begin
            s1_word_next = masked >> start_bit_reg;
            s1_flen_next = len_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_word_reg <= s1_word_next;
            s1_flen_reg <= s1_flen_next;
            s1_zero_reg <= zero_case;
        end
    end

    // ---------------- stage 2: cut field, sign-extend ----------------
    logic [63:0] raw_next;
    logic [63:0] vbits_next;
    logic        vsign_next;
    logic [6:0]  top_shift;
    logic [5:0]  sign_pos;

    logic [63:0] s2_raw_reg;
    logic [63:0] s2_vbits_reg;
    logic        s2_vsign_reg;
    logic        s2_zero_reg;

    always_comb
    begin
        top_shift = csd_pkg::MAX_LEN - s1_flen_reg;
        sign_pos  = 6'(len_clamped - 7'd1);
        if (s1_zero_reg)
        begin
            raw_next = '0;
        end
        else if (big_endian_reg)
        begin
            raw_next = (s1_flen_reg == 7'd0) ? '0 : (s1_word_reg >> top_shift[5:0]);
        end
        else
        begin
            raw_next = s1_word_reg & csd_pkg::len_mask(s1_flen_reg);
        end
        vbits_next = raw_next;
        if (is_signed_reg && (len_clamped != 7'd0) && (len_clamped < csd_pkg::MAX_LEN)
            && raw_next[sign_pos])
        begin
            vbits_next = raw_next | ~csd_pkg::len_mask(len_clamped);
        end
        vsign_next = is_signed_reg && vbits_next[63];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_raw_reg   <= raw_next;
            s2_vbits_reg <= vbits_next;
            s2_vsign_reg <= vsign_next;
            s2_zero_reg  <= s1_zero_reg;
        end
    end

    // ---------------- stage 3: partial products ----------------
    logic signed [32:0] lo_op;
    logic signed [32:0] hi_op;
    logic signed [31:0] factor_s;
    logic signed [64:0] pl_next;
    logic signed [64:0] ph_next;

    logic [64:0] s3_pl_reg;
    logic [64:0] s3_ph_reg;
    logic [63:0] s3_raw_reg;
    logic        s3_zero_reg;

    assign lo_op    = $signed({1'b0, s2_vbits_reg[31:0]});
    assign hi_op    = $signed({s2_vsign_reg, s2_vbits_reg[63:32]});
    assign factor_s = $signed(scale_factor_reg);
    assign pl_next  = lo_op * factor_s;
    assign ph_next  = hi_op * factor_s;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_pl_reg   <= pl_next;
            s3_ph_reg   <= ph_next;
            s3_raw_reg  <= s2_raw_reg;
            s3_zero_reg <= s2_zero_reg;
        end
    end

    // ---------------- stage 4: sum partial products ----------------
    logic [96:0] prod_next;
    logic [96:0] s4_prod_reg;
    logic [63:0] s4_raw_reg;
    logic        s4_zero_reg;

    assign prod_next = {s3_ph_reg, 32'd0} + {{32{s3_pl_reg[64]}}, s3_pl_reg};

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_prod_reg <= prod_next;
            s4_raw_reg  <= s3_raw_reg;
            s4_zero_reg <= s3_zero_reg;
        end
    end

    // ---------------- stage 5: offset, saturate ----------------
    logic [97:0] sum;
    logic        sat_next;
    logic [63:0] scaled_next;

    logic [63:0] s5_raw_reg;
    logic [63:0] s5_scaled_reg;
    logic        s5_sat_reg;

    always_comb
    begin
        sum = {s4_prod_reg[96], s4_prod_reg}
            + {{50{scale_offset_reg[47]}}, scale_offset_reg};
        if (s4_zero_reg)
        begin
            sat_next    = 1'b0;
            scaled_next = '0;
        end
        else if (sum[97:63] != {35{sum[63]}})
        begin
            sat_next    = 1'b1;
            scaled_next = sum[97] ? csd_pkg::SAT_MIN : csd_pkg::SAT_MAX;
        end
        else
        begin
            sat_next    = 1'b0;
            scaled_next = sum[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_raw_reg    <= s4_raw_reg;
            s5_scaled_reg <= scaled_next;
            s5_sat_reg    <= sat_next;
        end
    end

    assign m_axis_tvalid = s5_valid_reg;
    assign m_axis_tdata  = {s5_scaled_reg, s5_raw_reg};
    assign m_axis_tuser  = s5_sat_reg;

    // ---------------- assertions ----------------
    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[127:64] == csd_pkg::SAT_MAX || m_axis_tdata[127:64] == csd_pkg::SAT_MIN))
        else $error("saturated result not at a range limit");

    a_raw_width: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && len_clamped != 7'd0 && len_clamped < csd_pkg::MAX_LEN) |->
        ((m_axis_tdata[63:0] & ~csd_pkg::len_mask(len_clamped)) == 64'd0))
        else $error("raw field wider than signal length");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !en4) |=> (s3_valid_reg && $stable(s3_pl_reg) && $stable(s3_ph_reg)))
        else $error("stalled stage lost its product");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && en2) |=> s2_valid_reg)
        else $error("request dropped between stages");

endmodule
